// ===== sv/bdc3d_pkg.sv =====
// ----------------------------------------------------------------------------
// bdc3d_pkg: shared types and constants for the 3D backward-difference curl
// Sizes, field widths, register indexes and the structs that pass between
// the front end, the item queue and the back end.
// ----------------------------------------------------------------------------
package bdc3d_pkg;

   // default grid limits
   localparam int MAX_X_DEF = 64;
   localparam int MAX_Y_DEF = 64;
   localparam int MAX_Z_DEF = 4096;

   // field widths
   localparam int COMP_W = 32;
   localparam int DIFF_W = 33;
   localparam int CURL_W = 34;

   // configuration registers
   localparam int SX_W   = 7;
   localparam int SY_W   = 7;
   localparam int SZ_W   = 13;
   localparam int CSR_DW = 13;
   localparam int CSR_IW = 2;

   localparam logic [CSR_IW-1:0] CSR_SIZE_X = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_SIZE_Y = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_SIZE_Z = 2'd2;

   // effective (clamped) grid size
   typedef struct packed {
      logic [SX_W-1:0] sx;
      logic [SY_W-1:0] sy;
      logic [SZ_W-1:0] sz;
   } bdc_size_type;

   // per-sample classification made by the front end
   typedef struct packed {
      logic has_x;
      logic has_y;
      logic has_z;
      logic vol_end;
   } bdc_flag_type;

   // one field sample
   typedef struct packed {
      logic signed [COMP_W-1:0] cz;
      logic signed [COMP_W-1:0] cy;
      logic signed [COMP_W-1:0] cx;
   } bdc_sample_type;

   localparam int FLAG_W   = $bits(bdc_flag_type);
   localparam int SAMPLE_W = $bits(bdc_sample_type);

endpackage

// ===== sv/bdc3d_if.sv =====
// ----------------------------------------------------------------------------
// bdc3d_if: request and response channels of the curl block
// Valid/ready channels carrying one field sample or one curl result.
// ----------------------------------------------------------------------------
interface bdc3d_req_if import bdc3d_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [COMP_W-1:0] comp_x;
   logic signed [COMP_W-1:0] comp_y;
   logic signed [COMP_W-1:0] comp_z;

   modport source (output valid, output comp_x, output comp_y, output comp_z,
                   input ready);
   modport sink   (input valid, input comp_x, input comp_y, input comp_z,
                   output ready);
endinterface

interface bdc3d_rsp_if import bdc3d_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [CURL_W-1:0] curl_x;
   logic signed [CURL_W-1:0] curl_y;
   logic signed [CURL_W-1:0] curl_z;
   logic                     volume_end;

   modport source (output valid, output curl_x, output curl_y, output curl_z,
                   output volume_end, input ready);
   modport sink   (input valid, input curl_x, input curl_y, input curl_z,
                   input volume_end, output ready);
endinterface

// ===== sv/bdc3d_front.sv =====
// ----------------------------------------------------------------------------
// bdc3d_front: sample intake and raster position tracking
// Keeps the x/y/z position, tags each sample with its neighbor flags,
// last-of-volume flag and plane store addresses, and pushes it to the queue.
// ----------------------------------------------------------------------------
module bdc3d_front import bdc3d_pkg::*; #(
   parameter int MAX_X = MAX_X_DEF,
   parameter int MAX_Y = MAX_Y_DEF,
   parameter int MAX_Z = MAX_Z_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  bdc_size_type      sizes,
   bdc3d_req_if.sink         req_ch,
   output logic              push_valid,
   input  logic              push_ready,
   output bdc_sample_type    push_sample,
   output bdc_flag_type      push_flags,
   output logic [((MAX_X*MAX_Y) > 1 ? $clog2(MAX_X*MAX_Y) : 1)-1:0] push_wa,
   output logic [((MAX_X*MAX_Y) > 1 ? $clog2(MAX_X*MAX_Y) : 1)-1:0] push_ua
);

   localparam int XW = (MAX_X > 1) ? $clog2(MAX_X) : 1;
   localparam int YW = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
   localparam int ZW = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
   localparam int AW = ((MAX_X*MAX_Y) > 1) ? $clog2(MAX_X*MAX_Y) : 1;

   logic [XW-1:0] pos_x_ff, pos_x_in;
   logic [YW-1:0] pos_y_ff, pos_y_in;
   logic [ZW-1:0] pos_z_ff, pos_z_in;
   logic [AW-1:0] row_ff, row_in;     // pos_y * MAX_X
   logic          accept;
   logic          last_x, last_y, last_z;

   assign accept = req_ch.valid && push_ready;
   assign req_ch.ready = push_ready;

   // a position at or past the size counts as the last index
   assign last_x = (32'(pos_x_ff) + 32'd1) >= 32'(sizes.sx);
   assign last_y = (32'(pos_y_ff) + 32'd1) >= 32'(sizes.sy);
   assign last_z = (32'(pos_z_ff) + 32'd1) >= 32'(sizes.sz);

   always_comb begin
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      pos_z_in = pos_z_ff;
      row_in   = row_ff;
      if (accept) begin
         if (!last_x) begin
            pos_x_in = pos_x_ff + 1'b1;
         end else begin
            pos_x_in = '0;
            if (!last_y) begin
               pos_y_in = pos_y_ff + 1'b1;
               row_in   = row_ff + AW'(MAX_X);
            end else begin
               pos_y_in = '0;
               row_in   = '0;
               pos_z_in = last_z ? '0 : pos_z_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         pos_z_ff <= '0;
         row_ff   <= '0;
      end else begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         pos_z_ff <= pos_z_in;
         row_ff   <= row_in;
      end
   end

   assign push_valid     = req_ch.valid;
   assign push_sample.cx = req_ch.comp_x;
   assign push_sample.cy = req_ch.comp_y;
   assign push_sample.cz = req_ch.comp_z;

   assign push_flags.has_x   = (pos_x_ff != '0);
   assign push_flags.has_y   = (pos_y_ff != '0);
   assign push_flags.has_z   = (pos_z_ff != '0);
   assign push_flags.vol_end = last_x && last_y && last_z;

   // ua is junk on row 0; has_y masks it
   assign push_wa = row_ff + AW'(pos_x_ff);
   assign push_ua = push_wa - AW'(MAX_X);

endmodule

// ===== sv/bdc3d_fifo.sv =====
// ----------------------------------------------------------------------------
// bdc3d_fifo: two-entry item queue
// Decouples the intake from the plane store pipeline.
// ----------------------------------------------------------------------------
module bdc3d_fifo import bdc3d_pkg::*; #(
   parameter int W = SAMPLE_W
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [W-1:0] in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [W-1:0] out_data
);

   logic [W-1:0] entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// ===== sv/bdc3d_back.sv =====
// ----------------------------------------------------------------------------
// bdc3d_back: plane store and curl pipeline
// Stage A: plane store read of z-1 and y-1 neighbors, write of the sample.
// Stage B: six neighbor differences. Stage C: curl sums, output register.
// ----------------------------------------------------------------------------
module bdc3d_back import bdc3d_pkg::*; #(
   parameter int MAX_X = MAX_X_DEF,
   parameter int MAX_Y = MAX_Y_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           q_valid,
   output logic           q_ready,
   input  bdc_sample_type q_sample,
   input  bdc_flag_type   q_flags,
   input  logic [((MAX_X*MAX_Y) > 1 ? $clog2(MAX_X*MAX_Y) : 1)-1:0] q_wa,
   input  logic [((MAX_X*MAX_Y) > 1 ? $clog2(MAX_X*MAX_Y) : 1)-1:0] q_ua,
   bdc3d_rsp_if.source    rsp_ch
);

   localparam int DEPTH = MAX_X * MAX_Y;

   // plane store: written and read in the same cycle; read returns old data
   bdc_sample_type store_mem [DEPTH];

   logic pop, a_ready, b_ready, c_ready, b_load, c_load;

   // stage A
   logic           a_valid_ff, a_valid_in;
   bdc_sample_type a_smp_ff;
   bdc_sample_type a_nx_ff;
   bdc_flag_type   a_flags_ff;
   bdc_sample_type nz_ff, ny_ff;
   bdc_sample_type prev_ff;

   // stage B
   logic                     b_valid_ff, b_valid_in;
   bdc_flag_type             b_flags_ff;
   logic signed [DIFF_W-1:0] dy_z_ff, dz_y_ff, dz_x_ff, dx_z_ff, dx_y_ff, dy_x_ff;
   logic signed [DIFF_W-1:0] dy_z_in, dz_y_in, dz_x_in, dx_z_in, dx_y_in, dy_x_in;

   // stage C
   logic                     c_valid_ff, c_valid_in;
   logic signed [CURL_W-1:0] curl_x_ff, curl_y_ff, curl_z_ff;
   logic signed [CURL_W-1:0] curl_x_in, curl_y_in, curl_z_in;
   logic                     vol_end_ff;

   assign c_ready = !c_valid_ff || rsp_ch.ready;
   assign b_ready = !b_valid_ff || c_ready;
   assign a_ready = !a_valid_ff || b_ready;
   assign q_ready = a_ready;
   assign pop     = q_valid && a_ready;
   assign b_load  = a_valid_ff && b_ready;
   assign c_load  = b_valid_ff && c_ready;

   assign a_valid_in = a_ready ? q_valid    : a_valid_ff;
   assign b_valid_in = b_ready ? a_valid_ff : b_valid_ff;
   assign c_valid_in = c_ready ? b_valid_ff : c_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         prev_ff    <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
         if (pop) begin
            prev_ff <= q_sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         store_mem[q_wa] <= q_sample;
         nz_ff           <= store_mem[q_wa];
         ny_ff           <= store_mem[q_ua];
         a_smp_ff        <= q_sample;
         a_nx_ff         <= prev_ff;
         a_flags_ff      <= q_flags;
      end
   end

   // dA(c): sample.c - neighborA.c, zero without neighbor
   always_comb begin
      dy_z_in = a_flags_ff.has_y ? DIFF_W'($signed(a_smp_ff.cz)) - DIFF_W'($signed(ny_ff.cz)) : '0;
      dy_x_in = a_flags_ff.has_y ? DIFF_W'($signed(a_smp_ff.cx)) - DIFF_W'($signed(ny_ff.cx)) : '0;
      dz_y_in = a_flags_ff.has_z ? DIFF_W'($signed(a_smp_ff.cy)) - DIFF_W'($signed(nz_ff.cy)) : '0;
      dz_x_in = a_flags_ff.has_z ? DIFF_W'($signed(a_smp_ff.cx)) - DIFF_W'($signed(nz_ff.cx)) : '0;
      dx_z_in = a_flags_ff.has_x ? DIFF_W'($signed(a_smp_ff.cz)) - DIFF_W'($signed(a_nx_ff.cz)) : '0;
      dx_y_in = a_flags_ff.has_x ? DIFF_W'($signed(a_smp_ff.cy)) - DIFF_W'($signed(a_nx_ff.cy)) : '0;
   end

   always_ff @(posedge clock) begin
      if (b_load) begin
         dy_z_ff    <= dy_z_in;
         dz_y_ff    <= dz_y_in;
         dz_x_ff    <= dz_x_in;
         dx_z_ff    <= dx_z_in;
         dx_y_ff    <= dx_y_in;
         dy_x_ff    <= dy_x_in;
         b_flags_ff <= a_flags_ff;
      end
   end

   assign curl_x_in = CURL_W'(dy_z_ff) - CURL_W'(dz_y_ff);
   assign curl_y_in = CURL_W'(dz_x_ff) - CURL_W'(dx_z_ff);
   assign curl_z_in = CURL_W'(dx_y_ff) - CURL_W'(dy_x_ff);

   always_ff @(posedge clock) begin
      if (c_load) begin
         curl_x_ff  <= curl_x_in;
         curl_y_ff  <= curl_y_in;
         curl_z_ff  <= curl_z_in;
         vol_end_ff <= b_flags_ff.vol_end;
      end
   end

   assign rsp_ch.valid      = c_valid_ff;
   assign rsp_ch.curl_x     = curl_x_ff;
   assign rsp_ch.curl_y     = curl_y_ff;
   assign rsp_ch.curl_z     = curl_z_ff;
   assign rsp_ch.volume_end = vol_end_ff;

`ifndef SYNTHESIS
   a_pop_fills_stage_a: assert property (@(posedge clock) disable iff (reset)
      pop |=> a_valid_ff)
      else $error("popped transaction did not reach stage A");

   // neighbor reads of unwritten entries may hold X; compare with ===
   a_stage_a_holds: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && !b_ready) |=>
         (a_valid_ff && (a_smp_ff === $past(a_smp_ff)) &&
          (nz_ff === $past(nz_ff)) && (ny_ff === $past(ny_ff))))
      else $error("stage A lost its data under stall");

   a_origin_zero: assert property (@(posedge clock) disable iff (reset)
      (c_load && !b_flags_ff.has_x && !b_flags_ff.has_y && !b_flags_ff.has_z) |=>
         (curl_x_ff == '0 && curl_y_ff == '0 && curl_z_ff == '0))
      else $error("curl not zero for a sample without neighbors");
`endif

endmodule

// ===== sv/backward_difference_curl_3d.sv =====
// ----------------------------------------------------------------------------
// backward_difference_curl_3d: streaming backward-difference curl of a 3D field
// Samples arrive in raster order (x fastest); each yields its curl from the
// x-1 sample, the y-1 and z-1 entries of a one-plane store.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------
//  req_ch  | in  | valid/ready        | comp_x, comp_y, comp_z (s32 Q16.16)
//  rsp_ch  | out | valid/ready        | curl_x/y/z (s34 Q18.16), volume_end
//  csr     | in  | csr_we, no wait    | csr_idx 0:size_x 1:size_y 2:size_z
//
//  Throughput: one transaction per cycle in both directions while the
//  result side holds ready high; the plane store does one write and two
//  reads per sample on a single cycle. A result passes through the queue,
//  the store read, the differences and the curl register, in that order.
//  Reset: synchronous; positions go to the origin, sizes to 64. The plane
//  store is not cleared; no clearing pass, samples are taken right away.
//  Stalls: a 2-entry queue and per-stage valid bits let intake and the
//  result side stall independently.
//
module backward_difference_curl_3d import bdc3d_pkg::*; #(
   parameter int MAX_X = MAX_X_DEF,
   parameter int MAX_Y = MAX_Y_DEF,
   parameter int MAX_Z = MAX_Z_DEF
) (
   input  logic              clock,
   input  logic              reset,
   bdc3d_req_if.sink         req_ch,
   bdc3d_rsp_if.source       rsp_ch,
   input  logic              csr_we,
   input  logic [CSR_IW-1:0] csr_idx,
   input  logic [CSR_DW-1:0] csr_wdata
);

   localparam int AW = ((MAX_X*MAX_Y) > 1) ? $clog2(MAX_X*MAX_Y) : 1;
   localparam int QW = FLAG_W + 2*AW + SAMPLE_W;

   // ---- configuration registers ----
   logic [SX_W-1:0] size_x_ff, size_x_in;
   logic [SY_W-1:0] size_y_ff, size_y_in;
   logic [SZ_W-1:0] size_z_ff, size_z_in;
   bdc_size_type    sizes;

   always_comb begin
      size_x_in = size_x_ff;
      size_y_in = size_y_ff;
      size_z_in = size_z_ff;
      if (csr_we) begin
         case (csr_idx)
            CSR_SIZE_X: size_x_in = csr_wdata[SX_W-1:0];
            CSR_SIZE_Y: size_y_in = csr_wdata[SY_W-1:0];
            CSR_SIZE_Z: size_z_in = csr_wdata[SZ_W-1:0];
            default: ;   // unused index: ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= SX_W'(64);
         size_y_ff <= SY_W'(64);
         size_z_ff <= SZ_W'(64);
      end else begin
         size_x_ff <= size_x_in;
         size_y_ff <= size_y_in;
         size_z_ff <= size_z_in;
      end
   end

   // zero acts as one, anything above the limit as the limit
   always_comb begin
      sizes.sx = (size_x_ff == '0) ? SX_W'(1) :
                 (32'(size_x_ff) > 32'(MAX_X)) ? SX_W'(MAX_X) : size_x_ff;
      sizes.sy = (size_y_ff == '0) ? SY_W'(1) :
                 (32'(size_y_ff) > 32'(MAX_Y)) ? SY_W'(MAX_Y) : size_y_ff;
      sizes.sz = (size_z_ff == '0) ? SZ_W'(1) :
                 (32'(size_z_ff) > 32'(MAX_Z)) ? SZ_W'(MAX_Z) : size_z_ff;
   end

   // ---- front end: position tracking and tagging ----
   logic           push_valid, push_ready;
   bdc_sample_type push_sample;
   bdc_flag_type   push_flags;
   logic [AW-1:0]  push_wa, push_ua;

   bdc3d_front #(
      .MAX_X (MAX_X),
      .MAX_Y (MAX_Y),
      .MAX_Z (MAX_Z)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .sizes       (sizes),
      .req_ch      (req_ch),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_sample (push_sample),
      .push_flags  (push_flags),
      .push_wa     (push_wa),
      .push_ua     (push_ua)
   );

   // ---- item queue ----
   logic           q_valid, q_ready;
   logic [QW-1:0]  q_data;
   bdc_sample_type q_sample;
   bdc_flag_type   q_flags;
   logic [AW-1:0]  q_wa, q_ua;

   bdc3d_fifo #(
      .W (QW)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   ({push_flags, push_ua, push_wa, push_sample}),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   assign {q_flags, q_ua, q_wa, q_sample} = q_data;

   // ---- back end: plane store and curl arithmetic ----
   bdc3d_back #(
      .MAX_X (MAX_X),
      .MAX_Y (MAX_Y)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_sample (q_sample),
      .q_flags  (q_flags),
      .q_wa     (q_wa),
      .q_ua     (q_ua),
      .rsp_ch   (rsp_ch)
   );

endmodule

// ===== bench/bdc3d_curl_checker.sv =====
// ----------------------------------------------------------------------------
// bdc3d_curl_checker: curl predictor and result checker
// Watches the sample and curl channels and the register port, keeps its own
// grid position and plane copy, and compares every curl result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bdc3d_curl_checker import bdc3d_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   bdc3d_req_if              req_ch,
   bdc3d_rsp_if              rsp_ch,
   input  logic              csr_we,
   input  logic [CSR_IW-1:0] csr_idx,
   input  logic [CSR_DW-1:0] csr_wdata,
   output int                fail_count,
   output int                outstanding
);

   typedef struct packed {
      logic signed [CURL_W-1:0] cx;
      logic signed [CURL_W-1:0] cy;
      logic signed [CURL_W-1:0] cz;
      logic                     vend;
   } curl_result_type;

   bdc_sample_type                  plane_mem [MAX_X_DEF*MAX_Y_DEF];
   bdc_sample_type                  last_sample;
   logic [$clog2(MAX_X_DEF)-1:0]    at_x;
   logic [$clog2(MAX_Y_DEF)-1:0]    at_y;
   logic [$clog2(MAX_Z_DEF)-1:0]    at_z;
   logic [SX_W-1:0]                 grid_x;
   logic [SY_W-1:0]                 grid_y;
   logic [SZ_W-1:0]                 grid_z;
   curl_result_type                 curl_due [$];

   function automatic int clamp_axis(int raw, int lim);
      if (raw == 0) return 1;
      if (raw > lim) return lim;
      return raw;
   endfunction

   // backward difference, zero when the neighbour is off the grid
   function automatic logic signed [CURL_W-1:0] delta(logic signed [COMP_W-1:0] a,
                                                      logic signed [COMP_W-1:0] b,
                                                      logic present);
      logic signed [CURL_W-1:0] wa;
      logic signed [CURL_W-1:0] wb;
      wa = a;
      wb = b;
      return present ? wa - wb : '0;
   endfunction

   function automatic curl_result_type next_curl(bdc_sample_type s);
      int              sx, sy, sz, here;
      logic            hx, hy, hz, lx, ly, lz;
      bdc_sample_type  ny, nz;
      curl_result_type r;
      sx   = clamp_axis(grid_x, MAX_X_DEF);
      sy   = clamp_axis(grid_y, MAX_Y_DEF);
      sz   = clamp_axis(grid_z, MAX_Z_DEF);
      hx   = at_x != 0;
      hy   = at_y != 0;
      hz   = at_z != 0;
      here = at_y * MAX_X_DEF + at_x;
      ny   = hy ? plane_mem[(at_y - 1) * MAX_X_DEF + at_x] : '0;
      nz   = plane_mem[here];

      r.cx = delta(s.cz, ny.cz, hy) - delta(s.cy, nz.cy, hz);
      r.cy = delta(s.cx, nz.cx, hz) - delta(s.cz, last_sample.cz, hx);
      r.cz = delta(s.cy, last_sample.cy, hx) - delta(s.cx, ny.cx, hy);

      plane_mem[here] = s;
      last_sample     = s;

      // a counter at or past a shrunken size is on its last index
      lx     = at_x + 1 >= sx;
      ly     = at_y + 1 >= sy;
      lz     = at_z + 1 >= sz;
      r.vend = lx && ly && lz;

      if (!lx) begin
         at_x = at_x + 1'b1;
      end else begin
         at_x = '0;
         if (!ly) begin
            at_y = at_y + 1'b1;
         end else begin
            at_y = '0;
            at_z = lz ? '0 : at_z + 1'b1;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      bdc_sample_type  s;
      curl_result_type want, got;
      if (reset) begin
         last_sample = '0;
         at_x        = '0;
         at_y        = '0;
         at_z        = '0;
         grid_x      = SX_W'(64);
         grid_y      = SY_W'(64);
         grid_z      = SZ_W'(64);
         curl_due.delete();
         fail_count  = 0;
         outstanding = 0;
      end else begin
         if (csr_we) begin
            case (csr_idx)
               CSR_SIZE_X: grid_x = csr_wdata[SX_W-1:0];
               CSR_SIZE_Y: grid_y = csr_wdata[SY_W-1:0];
               CSR_SIZE_Z: grid_z = csr_wdata[SZ_W-1:0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            s.cx = req_ch.comp_x;
            s.cy = req_ch.comp_y;
            s.cz = req_ch.comp_z;
            curl_due.push_back(next_curl(s));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.cx   = rsp_ch.curl_x;
            got.cy   = rsp_ch.curl_y;
            got.cz   = rsp_ch.curl_z;
            got.vend = rsp_ch.volume_end;
            if (curl_due.size() == 0) begin
               if (fail_count < 10)
                  $display("%t: curl result with no sample pending: x=%0d y=%0d z=%0d end=%0b",
                           $realtime, got.cx, got.cy, got.cz, got.vend);
               fail_count++;
            end else begin
               want = curl_due.pop_front();
               if (want.cx !== got.cx || want.cy !== got.cy ||
                   want.cz !== got.cz || want.vend !== got.vend) begin
                  if (fail_count < 10) begin
                     $display("%t: curl mismatch", $realtime);
                     $display("   want x=%0d y=%0d z=%0d end=%0b",
                              want.cx, want.cy, want.cz, want.vend);
                     $display("   got  x=%0d y=%0d z=%0d end=%0b",
                              got.cx, got.cy, got.cz, got.vend);
                  end
                  fail_count++;
               end
            end
         end
         outstanding = curl_due.size();
      end
   end

endmodule

// ===== bench/backward_difference_curl_3d_tb.sv =====
// ----------------------------------------------------------------------------
// backward_difference_curl_3d_tb: stream test of the 3D backward-difference curl
// Feeds whole volumes of field samples over a range of grid sizes, with random
// stalls on both channels, and leaves prediction and checking to the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module backward_difference_curl_3d_tb;
   import bdc3d_pkg::*;

   localparam int RANDOM_ITEMS   = 1100;
   localparam int HOLD_AT        = 400;   // sample count that starts the long hold-off
   localparam int HOLD_OFF       = 300;   // cycles the result side holds ready low
   localparam int STEADY_FROM    = 700;   // window with no idling on either side
   localparam int STEADY_TO      = 850;
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction at all
   localparam int DRAIN_CYCLES   = 12;    // margin beyond the pipeline latency
   localparam int MAX_SPAN       = 300;   // samples in one random volume
   localparam int MAX_PHASE      = 400;   // samples between two register updates

   localparam logic [CSR_IW-1:0] CSR_SPARE = 2'd3;   // index with no register

   localparam logic signed [COMP_W-1:0] COMP_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COMP_W-1:0] COMP_MIN = 32'sh8000_0000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_we;
   logic [CSR_IW-1:0] csr_idx;
   logic [CSR_DW-1:0] csr_wdata;
   int                fail_count;
   int                outstanding;
   int                sent_count = 0;
   int                quiet_cycles = 0;
   logic              steady;

   bdc3d_req_if req_ch ();
   bdc3d_rsp_if rsp_ch ();

   always #5 clock = ~clock;

   backward_difference_curl_3d i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata)
   );

   bdc3d_curl_checker i_curl_checker (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_we      (csr_we),
      .csr_idx     (csr_idx),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // no idling on either side while this is high
   assign steady = sent_count >= STEADY_FROM && sent_count < STEADY_TO;

   // effective size of one axis as the block sees it: 0 acts as 1,
   // anything above the axis limit acts as the limit
   function automatic int axis_len(logic [CSR_DW-1:0] raw, int width, int lim);
      int v;
      v = raw & ((1 << width) - 1);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return v;
   endfunction

   // mostly small sizes; sometimes 0, the limit, or above it. Bits above
   // the register width are random and must be dropped by the block.
   function automatic logic [CSR_DW-1:0] pick_axis(int width, int lim);
      int r, v;
      r = $urandom_range(99);
      if (r < 60)      v = $urandom_range(1, 4);
      else if (r < 72) v = $urandom_range(5, 8);
      else if (r < 78) v = 0;
      else if (r < 86) v = lim;
      else             v = $urandom_range(lim + 1, (1 << width) - 1);
      return CSR_DW'(v) | (CSR_DW'($urandom) & ~CSR_DW'((1 << width) - 1));
   endfunction

   // field component, biased toward the extremes so differences reach the ends of 33 bits
   function automatic logic signed [COMP_W-1:0] pick_comp();
      int r;
      r = $urandom_range(99);
      if (r < 8)       return COMP_MIN;
      else if (r < 16) return COMP_MAX;
      else if (r < 20) return '0;
      else if (r < 24) return '1;
      else if (r < 40) return COMP_W'($urandom_range(0, 131071)) - 32'sd65536;
      else             return $urandom;
   endfunction

   // one sample transaction; entered and left at a falling edge
   task automatic send_sample(input logic signed [COMP_W-1:0] vx,
                              input logic signed [COMP_W-1:0] vy,
                              input logic signed [COMP_W-1:0] vz);
      while (!steady && $urandom_range(99) < 31) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.comp_x <= vx;
      req_ch.comp_y <= vy;
      req_ch.comp_z <= vz;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent_count++;
      @(negedge clock);
   endtask

   // stop offering and wait for every predicted curl to come back;
   // one result per sample, so the pipeline is empty then
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IW-1:0] idx, input logic [CSR_DW-1:0] data);
      csr_we    <= 1'b1;
      csr_idx   <= idx;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   task automatic set_grid(input logic [CSR_DW-1:0] gx,
                           input logic [CSR_DW-1:0] gy,
                           input logic [CSR_DW-1:0] gz);
      wait_drained();
      write_csr(CSR_SIZE_X, gx);
      write_csr(CSR_SIZE_Y, gy);
      write_csr(CSR_SIZE_Z, gz);
      csr_we <= 1'b0;
   endtask

   // Result side: random ready, one long hold-off while the sender keeps
   // offering (fills the block and backs up the input), and a steady stretch.
   initial begin : rsp_side
      int hold_left;
      bit held;
      hold_left    = 0;
      held         = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && sent_count >= HOLD_AT) begin
            held         = 1'b1;
            hold_left    = HOLD_OFF;
            rsp_ch.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
         end else begin
            rsp_ch.ready <= steady || $urandom_range(99) >= 31;
         end
      end
   end

   // Watchdog: any stretch with no transaction on either channel that is
   // far longer than the hold-off means the block hung.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin : stimulus
      logic signed [COMP_W-1:0] corner [4];
      logic [CSR_DW-1:0]        gx, gy, gz;
      int                       span, vols, phase, random_done;
      bit                       odd;

      corner[0] = '0;
      corner[1] = '1;
      corner[2] = COMP_MAX;
      corner[3] = COMP_MIN;

      req_ch.valid  = 1'b0;
      req_ch.comp_x = '0;
      req_ch.comp_y = '0;
      req_ch.comp_z = '0;
      csr_we        = 1'b0;
      csr_idx       = CSR_SIZE_X;
      csr_wdata     = '0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed part -----------------------------------------------
      // Write to the spare index must not disturb the sizes.
      wait_drained();
      write_csr(CSR_SPARE, '1);

      // 2x2x2 grid, size_x written with junk in the upper bits. Checkerboard
      // of full-scale values: every difference is +/-(2^32-1), so the curl
      // hits both ends of its range; the origin still gives zero.
      set_grid(13'h1F82, 13'd2, 13'd2);
      for (int k = 0; k < 8; k++) begin
         odd = k[0] ^ k[1] ^ k[2];
         if (odd) send_sample(COMP_MAX, COMP_MIN, COMP_MAX);
         else     send_sample(COMP_MIN, COMP_MAX, COMP_MIN);
      end

      // 1x1 columns: size_x 0 acts as 1, size_z above the limit acts as
      // 4096. Only z differences are live here.
      set_grid(13'd0, 13'h1F81, 13'h1FFF);
      for (int k = 0; k < 8; k++)
         send_sample(corner[k % 4], corner[(k + 1) % 4], corner[(k + 2) % 4]);

      // Shrink size_z mid-volume: z counter sits past the new size, so the
      // next sample ends the volume and wraps; then one full volume of 3.
      set_grid(13'd1, 13'd1, 13'd3);
      repeat (4) send_sample(pick_comp(), pick_comp(), pick_comp());

      // --- random part: whole volumes over random grid sizes ------------
      phase       = 0;
      random_done = 0;
      while (random_done < RANDOM_ITEMS) begin
         if (phase == 0) begin
            // widest row: size_x above the limit acts as 64
            gx = 13'd127;
            gy = 13'd1;
            gz = 13'd2;
         end else if (phase == 1) begin
            // tallest plane, size_z of 0 acts as 1
            gx = 13'd1;
            gy = 13'h1FC0;
            gz = 13'd0;
         end else begin
            span = 0;
            while (span == 0 || span > MAX_SPAN) begin
               gx   = pick_axis(SX_W, MAX_X_DEF);
               gy   = pick_axis(SY_W, MAX_Y_DEF);
               gz   = pick_axis(SZ_W, MAX_Z_DEF);
               span = axis_len(gx, SX_W, MAX_X_DEF) * axis_len(gy, SY_W, MAX_Y_DEF) *
                      axis_len(gz, SZ_W, MAX_Z_DEF);
            end
         end
         span = axis_len(gx, SX_W, MAX_X_DEF) * axis_len(gy, SY_W, MAX_Y_DEF) *
                axis_len(gz, SZ_W, MAX_Z_DEF);
         vols = $urandom_range(1, 3);
         while (vols > 1 && vols * span > MAX_PHASE) vols--;

         set_grid(gx, gy, gz);
         repeat (vols * span) send_sample(pick_comp(), pick_comp(), pick_comp());
         random_done += vols * span;
         phase++;
      end

      // --- wind down ------------------------------------------------------
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
